>>> rtl/scp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scp_pkg: stage command parser shared definitions
// Status codes, stage kinds, delimiter characters and value limits.
// ----------------------------------------------------------------------------
package scp_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_BAD_TYPE  = 3'd2,
    ST_BAD_PARAM = 3'd3,
    ST_PUMP_OVER = 3'd4,
    ST_TOK_COUNT = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    KIND_FILL = 2'd0,
    KIND_WASH = 2'd1,
    KIND_DRY  = 2'd2
  } kind_e;

  localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
  localparam logic [7:0] CH_F     = 8'h66;  // 'f'
  localparam logic [7:0] CH_W     = 8'h77;  // 'w'
  localparam logic [7:0] CH_D     = 8'h64;  // 'd'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  localparam int unsigned VAL_W = 17;
  localparam logic [VAL_W-1:0] VALUE_SAT = 17'd65536;
  localparam logic [7:0] MAX_PUMP_RST = 8'd3;

endpackage

>>> rtl/stage_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stage_command_parser: serial stage command frame parser
// Parses frames such as "f:3,120;" one byte per word and emits one status
// word per frame with stage kind, optional pump number and duration.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | to block  | in_valid_i / in_stall_o | data_byte_i, frame_end_i
//  out     | from block| out_valid_o/ out_stall_i| status_o, stage_kind_o,
//          |           |                         | pump_given_o, pump_number_o,
//          |           |                         | duration_o
//  cfg     | to block  | cfg_valid_i/ cfg_ready_o| cfg_max_pump_i
//
// One input word is taken every cycle while not stalled; the parse registers
// absorb each byte in the cycle it is accepted (decimal digits accumulate by
// shift-and-add x10). The frame-end word loads the result register, so its
// status word is visible in the cycle after acceptance. The input stalls
// only while a status word sits in the result register and the output side
// stalls it. Reset (rst_ni low, asynchronous) clears parse state, drops any
// pending result and sets max_pump to 3. The cfg port is always ready.
// ----------------------------------------------------------------------------
module stage_command_parser
  import scp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  stage_kind_o,
  output logic        pump_given_o,
  output logic [7:0]  pump_number_o,
  output logic [15:0] duration_o,

  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_max_pump_i
);

  // Byte counter saturates at MAX_FRAME_LEN + 1, so it must hold that value.
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_LEN + 2);
  localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_FRAME_LEN);

  // Parse state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       tok_q, tok_d;
  logic             in_tok_q, in_tok_d;
  logic [7:0]       type_char_q, type_char_d;
  logic [1:0]       type_len_q, type_len_d;
  logic             comma_q, comma_d;
  logic [1:0]       part_q, part_d;
  logic             in_part_q, in_part_d;
  logic [VAL_W-1:0] first_q, first_d;
  logic [VAL_W-1:0] second_q, second_d;
  logic             bad_q, bad_d;

  logic [7:0] max_pump_q;

  // Result register
  logic        out_valid_q, out_valid_d;
  status_e     status_q, status_d;
  kind_e       kind_q, kind_d;
  logic        given_q, given_d;
  logic [7:0]  pump_q, pump_d;
  logic [15:0] dur_q, dur_d;

  logic in_acc;
  logic is_delim, is_digit;
  logic [1:0] tok_n, part_n;
  logic [3:0] digit;
  logic [VAL_W-1:0] acc_src, acc_val;
  logic [VAL_W+3:0] acc_sum;
  logic type_ok;
  kind_e type_kind;

  // Hold input only while a status word waits and the consumer stalls.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign is_delim = (data_byte_i == CH_COLON) || (data_byte_i == CH_SEMI);
  assign is_digit = (data_byte_i >= CH_ZERO) && (data_byte_i <= CH_NINE);
  assign digit    = 4'(data_byte_i - CH_ZERO);

  // Token and part counters as they stand after this byte.
  assign tok_n  = (!in_tok_q && tok_q != 2'd3) ? tok_q + 2'd1 : tok_q;
  assign part_n = (!in_part_q && part_q != 2'd3) ? part_q + 2'd1 : part_q;

  // Decimal accumulate: v*10 + digit, saturating at VALUE_SAT.
  assign acc_src = (part_n == 2'd1) ? first_q : second_q;
  assign acc_sum = {1'b0, acc_src, 3'b000} + {3'b000, acc_src, 1'b0}
                 + {(VAL_W+4-4)'(0), digit};
  assign acc_val = (acc_sum > (VAL_W+4)'(VALUE_SAT)) ? VALUE_SAT : acc_sum[VAL_W-1:0];

  always_comb begin
    type_ok   = 1'b0;
    type_kind = KIND_FILL;
    if (type_len_q == 2'd1) begin
      unique case (type_char_q)
        CH_F: begin
          type_ok   = 1'b1;
          type_kind = KIND_FILL;
        end
        CH_W: begin
          type_ok   = 1'b1;
          type_kind = KIND_WASH;
        end
        CH_D: begin
          type_ok   = 1'b1;
          type_kind = KIND_DRY;
        end
        default: begin
          type_ok   = 1'b0;
          type_kind = KIND_FILL;
        end
      endcase
    end
  end

  // Parse-state update and result formation.
  always_comb begin
    cnt_d       = cnt_q;
    tok_d       = tok_q;
    in_tok_d    = in_tok_q;
    type_char_d = type_char_q;
    type_len_d  = type_len_q;
    comma_d     = comma_q;
    part_d      = part_q;
    in_part_d   = in_part_q;
    first_d     = first_q;
    second_d    = second_q;
    bad_d       = bad_q;

    out_valid_d = out_valid_q & out_stall_i;
    status_d    = status_q;
    kind_d      = kind_q;
    given_d     = given_q;
    pump_d      = pump_q;
    dur_d       = dur_q;

    if (in_acc) begin
      if (cnt_q <= MAX_LEN) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
      if (frame_end_i) begin
        // Build the status word, then clear parse state for the next frame.
        out_valid_d = 1'b1;
        kind_d      = type_kind;
        given_d     = 1'b0;
        pump_d      = '0;
        dur_d       = '0;
        priority if (cnt_d > MAX_LEN) begin
          status_d = ST_TOO_LONG;
        end else if (tok_q != 2'd2) begin
          status_d = ST_TOK_COUNT;
        end else if (!type_ok) begin
          status_d = ST_BAD_TYPE;
        end else if (bad_q) begin
          status_d = ST_BAD_PARAM;
        end else if (comma_q) begin
          if (part_q < 2'd2 || second_q[VAL_W-1]) begin
            status_d = ST_BAD_PARAM;
          end else if (first_q > {{(VAL_W-8){1'b0}}, max_pump_q}) begin
            status_d = ST_PUMP_OVER;
          end else begin
            status_d = ST_OK;
            given_d  = 1'b1;
            pump_d   = first_q[7:0];
            dur_d    = second_q[15:0];
          end
        end else if (first_q[VAL_W-1]) begin
          status_d = ST_BAD_PARAM;
        end else begin
          status_d = ST_OK;
          dur_d    = first_q[15:0];
        end

        cnt_d       = '0;
        tok_d       = '0;
        in_tok_d    = 1'b0;
        type_char_d = '0;
        type_len_d  = '0;
        comma_d     = 1'b0;
        part_d      = '0;
        in_part_d   = 1'b0;
        first_d     = '0;
        second_d    = '0;
        bad_d       = 1'b0;
      end else if (is_delim) begin
        in_tok_d = 1'b0;
      end else begin
        in_tok_d = 1'b1;
        tok_d    = tok_n;
        if (tok_n == 2'd1) begin
          // Type token: keep the first char, count length up to two.
          if (type_len_q == 2'd0) begin
            type_char_d = data_byte_i;
          end
          if (type_len_q != 2'd2) begin
            type_len_d = type_len_q + 2'd1;
          end
        end else if (tok_n == 2'd2) begin
          if (data_byte_i == CH_COMMA) begin
            comma_d   = 1'b1;
            in_part_d = 1'b0;
          end else begin
            in_part_d = 1'b1;
            part_d    = part_n;
            // Parts past the second are ignored.
            if (part_n != 2'd3) begin
              if (!is_digit) begin
                bad_d = 1'b1;
              end else if (part_n == 2'd1) begin
                first_d = acc_val;
              end else begin
                second_d = acc_val;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      tok_q       <= '0;
      in_tok_q    <= 1'b0;
      type_char_q <= '0;
      type_len_q  <= '0;
      comma_q     <= 1'b0;
      part_q      <= '0;
      in_part_q   <= 1'b0;
      first_q     <= '0;
      second_q    <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
      max_pump_q  <= MAX_PUMP_RST;
    end else begin
      cnt_q       <= cnt_d;
      tok_q       <= tok_d;
      in_tok_q    <= in_tok_d;
      type_char_q <= type_char_d;
      type_len_q  <= type_len_d;
      comma_q     <= comma_d;
      part_q      <= part_d;
      in_part_q   <= in_part_d;
      first_q     <= first_d;
      second_q    <= second_d;
      bad_q       <= bad_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_pump_q <= cfg_max_pump_i;
      end
    end
  end

  // Result payload: no reset needed, guarded by out_valid_q.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    kind_q   <= kind_d;
    given_q  <= given_d;
    pump_q   <= pump_d;
    dur_q    <= dur_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign stage_kind_o  = kind_q;
  assign pump_given_o  = given_q;
  assign pump_number_o = pump_q;
  assign duration_o    = dur_q;

`ifndef NO_ASSERTIONS
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_end_i) |=> out_valid_q)
    else $error("frame end accepted without a status word");

  a_end_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && frame_end_i) |=> (cnt_q == '0 && tok_q == 2'd0 && !bad_q))
    else $error("parse state not cleared after frame end");

  a_no_token_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_q == 2'd0) |-> (type_len_q == 2'd0 && part_q == 2'd0 && !comma_q))
    else $error("token data recorded before any token started");

  a_pump_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && given_q) |-> (status_q == ST_OK))
    else $error("pump reported with an error status");
`endif

endmodule
